FILE: sv/scmr_pkg.sv
// ----------------------------------------------------------------------------
// scmr_pkg
// Shared constants and helpers of the strided column maximum reduction.
// ----------------------------------------------------------------------------
package scmr_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int COL_W       = $clog2(MAX_COLUMNS);

    localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
    localparam logic [1:0] REG_SAMPLE_COUNT = 2'd1;
    localparam logic [1:0] REG_GROUP_COUNT  = 2'd2;

    localparam logic [63:0] NEG_INF_BITS = 64'hFFF0_0000_0000_0000;

    // Result of x > m for IEEE doubles; false when either is NaN.
    function automatic logic fp_gt(input logic [63:0] x, input logic [63:0] m);
        logic x_nan;
        logic m_nan;
        logic x_zero;
        logic m_zero;
        logic gt;
        x_nan  = (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
        m_nan  = (m[62:52] == 11'h7FF) && (m[51:0] != 52'd0);
        x_zero = (x[62:0] == 63'd0);
        m_zero = (m[62:0] == 63'd0);
        if (x[63] != m[63]) begin
            gt = !x[63] && !(x_zero && m_zero);
        end else if (!x[63]) begin
            gt = x[62:0] > m[62:0];
        end else begin
            gt = x[62:0] < m[62:0];
        end
        return gt && !x_nan && !m_nan;
    endfunction

endpackage

FILE: sv/scmr_seq.sv
// ----------------------------------------------------------------------------
// scmr_seq
// Configuration registers and column, sample and group counters.
// ----------------------------------------------------------------------------
module scmr_seq (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_data,
    input  logic                      advance,
    output logic [scmr_pkg::COL_W-1:0] col,
    output logic                      first_row,
    output logic                      last_row,
    output logic                      last_col,
    output logic                      last_grp,
    output logic                      pass_thru
);
    import scmr_pkg::*;

    logic [10:0] cols_reg;
    logic [15:0] samps_reg, groups_reg;
    logic [COL_W-1:0] col_reg;
    logic [15:0] row_reg, grp_reg;
    logic [10:0] cols_eff;
    logic [15:0] samps_eff, groups_eff;
    logic cfg_hit;

    // Clamp geometry to its meaningful range.
    always_comb begin
        cols_eff = (cols_reg == 11'd0) ? 11'd1 : cols_reg;
        if (cols_eff > 11'(MAX_COLUMNS)) cols_eff = 11'(MAX_COLUMNS);
        samps_eff  = (samps_reg == 16'd0) ? 16'd1 : samps_reg;
        groups_eff = (groups_reg == 16'd0) ? 16'd1 : groups_reg;
        cfg_hit    = cfg_valid && (cfg_index == REG_COLUMN_COUNT ||
                     cfg_index == REG_SAMPLE_COUNT || cfg_index == REG_GROUP_COUNT);
    end

    assign col       = col_reg;
    assign first_row = (row_reg == 16'd0);
    assign last_col  = ({1'b0, col_reg} + 11'd1 == cols_eff);
    assign last_row  = (row_reg + 16'd1 == samps_eff);
    assign last_grp  = (grp_reg + 16'd1 == groups_eff);
    assign pass_thru = (samps_eff == 16'd1);

    // Advance counters per transaction; restart on register write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= 11'd1; samps_reg <= 16'd1; groups_reg <= 16'd1;
            col_reg <= '0; row_reg <= '0; grp_reg <= '0;
        end else if (cfg_hit) begin
            case (cfg_index)
                REG_COLUMN_COUNT: cols_reg   <= cfg_data[10:0];
                REG_SAMPLE_COUNT: samps_reg  <= cfg_data;
                REG_GROUP_COUNT:  groups_reg <= cfg_data;
                default: ;
            endcase
            col_reg <= '0; row_reg <= '0; grp_reg <= '0;
        end else if (advance) begin
            if (!last_col) begin
                col_reg <= col_reg + 1'b1;
            end else begin
                col_reg <= '0;
                if (!last_row) begin
                    row_reg <= row_reg + 16'd1;
                end else begin
                    row_reg <= '0;
                    grp_reg <= last_grp ? 16'd0 : grp_reg + 16'd1;
                end
            end
        end
    end
endmodule

FILE: sv/strided_column_max_reduce_core.sv
// ----------------------------------------------------------------------------
// strided_column_max_reduce_core
// Per-column running maximum of IEEE doubles held in a column memory.
// ----------------------------------------------------------------------------
// One element is taken per cycle while s_ready is high. Stage 1 issues the
// memory read for the element's column; stage 2 compares against the read
// data (or the last value written, forwarded when the same column repeats)
// and writes back. Results leave through a two-entry output buffer, so a
// stall on the result side stops input only once two results are held, or
// one is held and another is being written, with none leaving in that cycle.
module strided_column_max_reduce_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_value_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_max_bits,
    output logic [9:0]  m_column_index,
    output logic        m_group_done,
    output logic        m_call_done
);
    import scmr_pkg::*;

    typedef struct packed {
        logic [63:0]      x;
        logic [COL_W-1:0] col;
        logic             first, lrow, lcol, lgrp, pass;
    } stg_t;

    typedef struct packed {
        logic [63:0] m;
        logic [9:0]  c;
        logic        gd, cd;
    } res_t;

    logic [63:0] mem [MAX_COLUMNS];
    logic [63:0] rd_reg;
    stg_t        st_reg;
    logic        st_v_reg;
    logic [63:0] wb_reg;
    logic [COL_W-1:0] wb_col_reg;
    logic        wb_v_reg;
    res_t        q_reg [2];
    logic [1:0]  cnt_reg;
    logic        rp_reg, wp_reg;

    logic accept;
    logic [COL_W-1:0] col;
    logic first_row, last_row, last_col, last_grp, pass_thru;
    logic [63:0] old, mx;
    logic push, pop;

    assign cfg_ready = 1'b1;
    // Leave room for the element in flight.
    assign s_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && (!push || pop)) ||
                     (cnt_reg == 2'd2 && pop && !push);
    assign accept  = s_valid && s_ready;

    scmr_seq u_seq (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .advance(accept),
        .col(col), .first_row(first_row), .last_row(last_row),
        .last_col(last_col), .last_grp(last_grp), .pass_thru(pass_thru)
    );

    // Read column memory, register the element.
    always_ff @(posedge aclk) begin
        rd_reg <= mem[col];
        st_reg <= '{x: s_value_bits, col: col, first: first_row, lrow: last_row,
                    lcol: last_col, lgrp: last_grp, pass: pass_thru};
        if (!aresetn) st_v_reg <= 1'b0;
        else          st_v_reg <= accept;
    end

    // Forward the last write when the same column follows.
    always_comb begin
        old = (wb_v_reg && wb_col_reg == st_reg.col) ? wb_reg : rd_reg;
        if (st_reg.first) old = NEG_INF_BITS;
        if (st_reg.pass)      mx = st_reg.x;
        else if (fp_gt(st_reg.x, old)) mx = st_reg.x;
        else                  mx = old;
        push = st_v_reg && st_reg.lrow;
        pop  = m_valid && m_ready;
    end

    // Write back and queue the result.
    always_ff @(posedge aclk) begin
        if (st_v_reg) mem[st_reg.col] <= mx;
        wb_reg     <= mx;
        wb_col_reg <= st_reg.col;
        if (push) q_reg[wp_reg] <= '{m: mx, c: 10'(st_reg.col), gd: st_reg.lcol,
                                     cd: st_reg.lcol && st_reg.lgrp};
        if (!aresetn) begin
            wb_v_reg <= 1'b0; cnt_reg <= '0; rp_reg <= 1'b0; wp_reg <= 1'b0;
        end else begin
            wb_v_reg <= st_v_reg;
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign m_valid        = (cnt_reg != 2'd0);
    assign m_max_bits     = q_reg[rp_reg].m;
    assign m_column_index = q_reg[rp_reg].c;
    assign m_group_done   = q_reg[rp_reg].gd;
    assign m_call_done    = q_reg[rp_reg].cd;

    // Buffer never overflows.
    a_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2) else $error("result buffer overflow");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (cnt_reg != 2'd2 || pop)) else $error("push into full buffer");
    a_call_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_call_done |-> m_group_done) else $error("call_done without group_done");
endmodule

FILE: tb/scmr_checker.sv
// ----------------------------------------------------------------------------
// scmr_checker
// Watches the value and result channels of the column maximum core, predicts
// each result from the accepted values and compares it field by field.
// ----------------------------------------------------------------------------
module scmr_checker
    import scmr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [63:0] s_value_bits,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_max_bits,
    input  logic [9:0]  m_column_index,
    input  logic        m_group_done,
    input  logic        m_call_done,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] max_bits;
        logic [9:0]  column_index;
        logic        group_done;
        logic        call_done;
    } col_max_t;

    col_max_t    max_queue[$];
    logic [10:0] columns_reg;
    logic [15:0] samples_reg;
    logic [15:0] groups_reg;
    logic [63:0] running_max[MAX_COLUMNS];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned grp_pos;

    // IEEE ordered greater-than, false with any NaN operand
    function automatic bit dbl_greater(logic [63:0] x, logic [63:0] m);
        bit xn;
        bit mn;
        xn = (x[62:52] == 11'h7FF) && (x[51:0] != 0);
        mn = (m[62:52] == 11'h7FF) && (m[51:0] != 0);
        if (xn || mn) return 0;
        if (x[62:0] == 0 && m[62:0] == 0) return 0;
        if (x[63] != m[63]) return !x[63];
        if (!x[63]) return x[62:0] > m[62:0];
        return x[62:0] < m[62:0];
    endfunction

    // Advance the column model by one value; queue a result on the last row
    task automatic predict_column_max(logic [63:0] x);
        int unsigned cols;
        int unsigned samps;
        int unsigned grps;
        logic [63:0] m;
        col_max_t r;
        cols  = (columns_reg == 0) ? 1 : (columns_reg > MAX_COLUMNS ? MAX_COLUMNS : columns_reg);
        samps = (samples_reg == 0) ? 1 : samples_reg;
        grps  = (groups_reg == 0) ? 1 : groups_reg;
        if (col_pos >= cols) col_pos = 0;
        if (row_pos >= samps) row_pos = 0;
        if (grp_pos >= grps) grp_pos = 0;
        if (samps == 1) begin
            m = x;
        end else begin
            m = (row_pos == 0) ? NEG_INF_BITS : running_max[col_pos];
            if (dbl_greater(x, m)) m = x;
        end
        running_max[col_pos] = m;
        if (row_pos + 1 == samps) begin
            r.max_bits     = m;
            r.column_index = col_pos[9:0];
            r.group_done   = (col_pos + 1 == cols);
            r.call_done    = (col_pos + 1 == cols) && (grp_pos + 1 == grps);
            max_queue.push_back(r);
        end
        if (col_pos + 1 != cols) begin
            col_pos++;
        end else begin
            col_pos = 0;
            if (row_pos + 1 != samps) begin
                row_pos++;
            end else begin
                row_pos = 0;
                grp_pos = (grp_pos + 1 == grps) ? 0 : grp_pos + 1;
            end
        end
    endtask

    always @(posedge aclk) begin
        col_max_t got;
        col_max_t want;
        if (!aresetn) begin
            columns_reg = 1;
            samples_reg = 1;
            groups_reg  = 1;
            col_pos = 0;
            row_pos = 0;
            grp_pos = 0;
            max_queue.delete();
            fail_count <= 0;
        end else begin
            // compare a result transaction with the oldest prediction
            if (m_valid && m_ready) begin
                got = '{m_max_bits, m_column_index, m_group_done, m_call_done};
                if (max_queue.size() == 0) begin
                    $display("%0t: unexpected result %h col %0d", $time,
                             m_max_bits, m_column_index);
                    fail_count <= fail_count + 1;
                end else begin
                    want = max_queue.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected max %h col %0d gd %b cd %b, got %h %0d %b %b",
                                 $time, want.max_bits, want.column_index, want.group_done,
                                 want.call_done, got.max_bits, got.column_index,
                                 got.group_done, got.call_done);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // register write restarts the call
            if (cfg_valid && cfg_ready && cfg_index <= REG_GROUP_COUNT) begin
                case (cfg_index)
                    REG_COLUMN_COUNT: columns_reg = cfg_data[10:0];
                    REG_SAMPLE_COUNT: samples_reg = cfg_data;
                    default:          groups_reg  = cfg_data;
                endcase
                col_pos = 0;
                row_pos = 0;
                grp_pos = 0;
            end
            if (s_valid && s_ready) predict_column_max(s_value_bits);
        end
        pending_count <= max_queue.size();
    end
endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the column maximum core: register settings over several call
// shapes, directed special doubles, then random values under varied idling.
// ----------------------------------------------------------------------------
module tb_top;
    import scmr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_value_bits;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_max_bits;
    logic [9:0]  m_column_index;
    logic        m_group_done;
    logic        m_call_done;
    int          fail_count;
    int          pending_count;
    int          src_idle_pct;
    int          sink_idle_pct;
    bit          sink_hold;

    strided_column_max_reduce_core dut (.*);
    scmr_checker u_checker (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    // Randomly stall the result side; hold off completely while sink_hold
    initial begin
        m_ready = 0;
        forever begin
            @(negedge aclk);
            m_ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Drop any value left offered, then write one register
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge aclk);
        s_valid   <= 0;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    // Offer one value; it stays valid after acceptance until the next
    // falling edge, where the next call or a drop replaces it
    task automatic send_value(logic [63:0] v);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_value_bits <= v;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop the source, wait for every predicted result, then let the pipeline drain
    task automatic drain();
        @(negedge aclk);
        s_valid <= 0;
        while (pending_count != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_shape(int cols, int samps, int grps);
        drain();
        write_reg(REG_COLUMN_COUNT, cols);
        write_reg(REG_SAMPLE_COUNT, samps);
        write_reg(REG_GROUP_COUNT, grps);
    endtask

    function automatic logic [63:0] rand_double();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v[62:52] = 11'h7FF;
            1: v[62:0] = 0;
            2: v[62:52] = 11'h400 + $urandom_range(3);
            3: v[62:52] = 11'h3FF;
            default: ;
        endcase
        return v;
    endfunction

    // Random call shapes; each run covers a whole call, or now and then half a call plus one value
    task automatic random_calls(int n_items);
        int cols;
        int samps;
        int grps;
        int total;
        while (n_items > 0) begin
            case ($urandom_range(5))
                0: cols = 1;
                1: cols = $urandom_range(9, 16);
                default: cols = $urandom_range(1, 8);
            endcase
            samps = ($urandom_range(4) == 0) ? 1 : $urandom_range(2, 5);
            grps = $urandom_range(1, 3);
            set_shape(cols, samps, grps);
            total = cols * samps * grps;
            if ($urandom_range(7) == 0) total = total / 2 + 1;
            repeat (total) send_value(rand_double());
            n_items -= total;
        end
    endtask

    initial begin
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        s_valid = 0;
        s_value_bits = 0;
        sink_hold = 0;
        src_idle_pct = 0;
        sink_idle_pct = 0;
        aresetn = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // pass-through at reset shape, extreme values and NaN
        send_value(64'h0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'h7FF8_0000_0000_0001);
        send_value(NEG_INF_BITS);
        // zero registers behave as one
        set_shape(0, 0, 0);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h7FF0_0000_0000_0000);
        // NaN keeps running max, signed zeros, infinity
        set_shape(2, 3, 2);
        send_value(64'h7FF8_0000_0000_0000); send_value(64'h8000_0000_0000_0000);
        send_value(64'h3FF0_0000_0000_0000); send_value(64'h0000_0000_0000_0000);
        send_value(64'hFFF8_0000_0000_0000); send_value(64'h7FF0_0000_0000_0000);
        send_value(64'hC000_0000_0000_0000); send_value(64'hBFF0_0000_0000_0000);
        send_value(64'hFFFF_FFFF_FFFF_FFFF); send_value(64'h0000_0000_0000_0001);
        send_value(64'h7FEF_FFFF_FFFF_FFFF); send_value(64'hFFEF_FFFF_FFFF_FFFF);
        // oversized column count saturates; max sample and group counts
        set_shape(16'h7FF, 1, 1);
        repeat (40) send_value(rand_double());
        set_shape(3, 16'hFFFF, 16'hFFFF);
        repeat (4) send_value(rand_double());
        set_shape(1, 2, 2);
        // restart on a write mid-call, unlisted index ignored
        send_value(64'h4000_0000_0000_0000);
        write_reg(2'd3, 16'hFFFF);
        send_value(64'h4010_0000_0000_0000);
        drain();

        // long receiver hold-off so the core fills and stalls its input
        set_shape(1, 1, 1);
        fork
            begin
                sink_hold = 1;
                repeat (60) @(negedge aclk);
                sink_hold = 0;
            end
            repeat (20) send_value(rand_double());
        join
        drain();

        src_idle_pct = 10; sink_idle_pct = 47;
        random_calls(200);
        src_idle_pct = 47; sink_idle_pct = 10;
        random_calls(200);
        src_idle_pct = 0; sink_idle_pct = 0;
        random_calls(200);
        drain();
        repeat (20) @(negedge aclk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
